/* rtl/tsw_pkg.sv */
// tsw_pkg: event kinds, result codes, register indexes and field widths
// for the task stall watchdog. No dependencies.
`timescale 1ns / 1ps

package tsw_pkg;

    localparam int unsigned KIND_W   = 3;
    localparam int unsigned TIME_W   = 32;
    localparam int unsigned MS_W     = 31;
    localparam int unsigned STREAK_W = 16;
    localparam int unsigned RES_W    = 2;
    localparam int unsigned CIDX_W   = 2;

    typedef logic [KIND_W-1:0]   t_kind;
    typedef logic [TIME_W-1:0]   t_time;
    typedef logic [MS_W-1:0]     t_ms;
    typedef logic [STREAK_W-1:0] t_streak;
    typedef logic [RES_W-1:0]    t_res;
    typedef logic [CIDX_W-1:0]   t_cidx;

    localparam t_kind KIND_START    = 3'd0;
    localparam t_kind KIND_PROGRESS = 3'd1;
    localparam t_kind KIND_FINISH   = 3'd2;
    localparam t_kind KIND_CANCEL   = 3'd3;
    localparam t_kind KIND_TICK     = 3'd4;

    localparam t_res RES_NONE      = 2'd0;
    localparam t_res RES_WALL      = 2'd1;
    localparam t_res RES_STALLED   = 2'd2;
    localparam t_res RES_CANCELLED = 2'd3;

    localparam t_cidx REG_WALL_LIMIT  = 2'd0;
    localparam t_cidx REG_STALL_THR   = 2'd1;
    localparam t_cidx REG_IDLE_NEEDED = 2'd2;

    localparam t_ms     MS_MAX     = {MS_W{1'b1}};
    localparam t_streak STREAK_MAX = {STREAK_W{1'b1}};

    // clamp a wrap difference to the 31-bit reporting range
    function automatic t_ms sat31(input t_time v);
        t_ms r;
        r = v[TIME_W-1] ? MS_MAX : v[MS_W-1:0];
        return r;
    endfunction

endpackage

/* rtl/task_stall_watchdog.sv */
// task_stall_watchdog: top level, event handling and result register.
// Depends on tsw_pkg.
`timescale 1ns / 1ps

// One request is taken per cycle while o_ready is high; its result appears
// in the output register on the following cycle and a new request is accepted
// in the same cycle as the previous result is taken, so the sustained rate
// is one event per cycle while i_ready is high, set by the single result
// register behind the event logic. o_ready drops only while a result waits
// and i_ready is low. Configuration writes are always accepted; write them
// only while no result is pending. Register indexes beyond the list are taken
// and ignored. All but the result data resets, with no clearing pass.
module task_stall_watchdog (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  tsw_pkg::t_cidx              i_cfg_index,
    input  logic [31:0]                 i_cfg_data,
    // event requests
    input  logic                        i_valid,
    output logic                        o_ready,
    input  tsw_pkg::t_kind              i_kind,
    input  tsw_pkg::t_time              i_now_ms,
    // results
    output logic                        o_valid,
    input  logic                        i_ready,
    output tsw_pkg::t_res               o_event_res,
    output tsw_pkg::t_ms                o_event_ms,
    output tsw_pkg::t_streak            o_idle_count,
    output logic                        o_is_cancelled,
    output tsw_pkg::t_ms                o_elapsed_ms
);

    // configuration registers
    tsw_pkg::t_ms     r_wall_limit;
    tsw_pkg::t_ms     r_stall_thr;
    tsw_pkg::t_streak r_idle_needed;

    // task state
    logic             r_started, n_started;
    logic             r_terminated, n_terminated;
    logic             r_cancelled, n_cancelled;
    tsw_pkg::t_time   r_start_time, n_start_time;
    tsw_pkg::t_time   r_prog_time, n_prog_time;
    tsw_pkg::t_streak r_idle_streak, n_idle_streak;
    logic             r_wall_fired, n_wall_fired;
    logic             r_stall_fired, n_stall_fired;

    // result register
    logic             r_out_valid;
    tsw_pkg::t_res    r_res, n_res;
    tsw_pkg::t_ms     r_ems, n_ems;
    tsw_pkg::t_streak r_icount, n_icount;
    logic             r_out_cancel;
    tsw_pkg::t_ms     r_elapsed, n_elapsed;

    logic             in_take;
    tsw_pkg::t_time   elapsed_raw;
    tsw_pkg::t_time   silent;
    tsw_pkg::t_streak streak_inc;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !r_out_valid || i_ready;
    assign in_take     = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wall_limit  <= '0;
            r_stall_thr   <= '0;
            r_idle_needed <= tsw_pkg::t_streak'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                tsw_pkg::REG_WALL_LIMIT:  r_wall_limit  <= i_cfg_data[tsw_pkg::MS_W-1:0];
                tsw_pkg::REG_STALL_THR:   r_stall_thr   <= i_cfg_data[tsw_pkg::MS_W-1:0];
                tsw_pkg::REG_IDLE_NEEDED: r_idle_needed <= i_cfg_data[tsw_pkg::STREAK_W-1:0];
                default: ;
            endcase
        end
    end

    // silence is measured against the absolute time of the last progress,
    // which equals start time plus the relative mark
    assign elapsed_raw = r_started ? (i_now_ms - r_start_time) : '0;
    assign silent      = i_now_ms - r_prog_time;
    assign streak_inc  = (r_idle_streak == tsw_pkg::STREAK_MAX) ? r_idle_streak
                                                                : r_idle_streak + 1'b1;

    always_comb begin
        n_started     = r_started;
        n_terminated  = r_terminated;
        n_cancelled   = r_cancelled;
        n_start_time  = r_start_time;
        n_prog_time   = r_prog_time;
        n_idle_streak = r_idle_streak;
        n_wall_fired  = r_wall_fired;
        n_stall_fired = r_stall_fired;
        n_res         = tsw_pkg::RES_NONE;
        n_ems         = '0;
        n_icount      = '0;
        n_elapsed     = r_started ? tsw_pkg::sat31(elapsed_raw) : '0;

        if (!r_terminated) begin
            unique case (i_kind)
                tsw_pkg::KIND_START: begin
                    n_started     = 1'b1;
                    n_start_time  = i_now_ms;
                    n_prog_time   = i_now_ms;
                    n_idle_streak = '0;
                    n_wall_fired  = 1'b0;
                    n_stall_fired = 1'b0;
                    n_elapsed     = '0;
                end
                tsw_pkg::KIND_PROGRESS: begin
                    // before start the mark is overwritten by the start anyway
                    n_prog_time   = i_now_ms;
                    n_idle_streak = '0;
                    n_stall_fired = 1'b0;
                end
                tsw_pkg::KIND_FINISH: begin
                    n_terminated = 1'b1;
                end
                tsw_pkg::KIND_CANCEL: begin
                    n_terminated = 1'b1;
                    n_cancelled  = 1'b1;
                    n_res        = tsw_pkg::RES_CANCELLED;
                end
                tsw_pkg::KIND_TICK: begin
                    if (r_started) begin
                        priority if (r_wall_limit != '0 && !r_wall_fired &&
                                     elapsed_raw >= {1'b0, r_wall_limit}) begin
                            n_wall_fired = 1'b1;
                            n_res        = tsw_pkg::RES_WALL;
                            n_ems        = tsw_pkg::sat31(elapsed_raw);
                        end else if (r_stall_thr != '0) begin
                            if (silent < {1'b0, r_stall_thr}) begin
                                n_idle_streak = '0;
                            end else begin
                                n_idle_streak = streak_inc;
                                if (streak_inc >= r_idle_needed && !r_stall_fired) begin
                                    n_stall_fired = 1'b1;
                                    n_res         = tsw_pkg::RES_STALLED;
                                    n_ems         = tsw_pkg::sat31(silent);
                                    n_icount      = streak_inc;
                                end
                            end
                        end else begin
                            // stall detection off, the tick only reports elapsed time
                            n_idle_streak = r_idle_streak;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started     <= 1'b0;
            r_terminated  <= 1'b0;
            r_cancelled   <= 1'b0;
            r_start_time  <= '0;
            r_prog_time   <= '0;
            r_idle_streak <= '0;
            r_wall_fired  <= 1'b0;
            r_stall_fired <= 1'b0;
        end else if (in_take) begin
            r_started     <= n_started;
            r_terminated  <= n_terminated;
            r_cancelled   <= n_cancelled;
            r_start_time  <= n_start_time;
            r_prog_time   <= n_prog_time;
            r_idle_streak <= n_idle_streak;
            r_wall_fired  <= n_wall_fired;
            r_stall_fired <= n_stall_fired;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_res        <= n_res;
            r_ems        <= n_ems;
            r_icount     <= n_icount;
            r_out_cancel <= n_cancelled;
            r_elapsed    <= n_elapsed;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_event_res    = r_res;
    assign o_event_ms     = r_ems;
    assign o_idle_count   = r_icount;
    assign o_is_cancelled = r_out_cancel;
    assign o_elapsed_ms   = r_elapsed;

    // a finished or cancelled task stays finished
    a_term_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_terminated |=> r_terminated)
        else $error("terminated flag cleared");

    // a cancel result always reports the cancelled flag
    a_cancel_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res == tsw_pkg::RES_CANCELLED) |-> r_out_cancel)
        else $error("cancel result without cancelled flag");

    // quiet results carry no event figures
    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_res == tsw_pkg::RES_NONE) |-> (r_ems == '0 && r_icount == '0))
        else $error("event figures on a quiet result");

    // an accepted start on a live task clears streak and fired flags
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_take && !r_terminated && i_kind == tsw_pkg::KIND_START)
        |=> (r_idle_streak == '0 && !r_wall_fired && !r_stall_fired && r_started))
        else $error("start did not clear the marks");

    // before any start the reported elapsed time is zero
    a_unstarted_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_started) |-> (r_elapsed == '0))
        else $error("elapsed reported before start");

endmodule

/* sim/task_stall_watchdog_tb.sv */
// task_stall_watchdog_tb: self-checking testbench for the task stall watchdog.
// Drives event and register requests, predicts every result and compares them.
// Depends on tsw_pkg and task_stall_watchdog.
`timescale 1ns / 1ps

module task_stall_watchdog_tb;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned DRAIN_CYCLES   = 8;
    localparam int unsigned MAX_REPORTS    = 10;
    localparam int unsigned PHASE_ITEMS    = 150;

    // indexes and kinds the block must take and ignore
    localparam tsw_pkg::t_cidx REG_SPARE     = 2'd3;
    localparam tsw_pkg::t_kind KIND_SPARE_LO = 3'd5;
    localparam tsw_pkg::t_kind KIND_SPARE_HI = 3'd7;

    localparam int unsigned GAP_MODE[4]   = '{0, 68, 0, 13};
    localparam int unsigned STALL_MODE[4] = '{0, 0, 68, 13};

    typedef struct packed {
        tsw_pkg::t_res    res;
        tsw_pkg::t_ms     ms;
        tsw_pkg::t_streak idle;
        logic             cancelled;
        tsw_pkg::t_ms     elapsed;
    } t_outcome;

    logic             i_clk;
    logic             i_rst_n     = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    tsw_pkg::t_cidx   i_cfg_index = tsw_pkg::REG_WALL_LIMIT;
    logic [31:0]      i_cfg_data  = '0;
    logic             i_valid     = 1'b0;
    logic             o_ready;
    tsw_pkg::t_kind   i_kind      = tsw_pkg::KIND_START;
    tsw_pkg::t_time   i_now_ms    = '0;
    logic             o_valid;
    logic             i_ready     = 1'b0;
    tsw_pkg::t_res    o_event_res;
    tsw_pkg::t_ms     o_event_ms;
    tsw_pkg::t_streak o_idle_count;
    logic             o_is_cancelled;
    tsw_pkg::t_ms     o_elapsed_ms;

    task_stall_watchdog uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_kind         (i_kind),
        .i_now_ms       (i_now_ms),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_event_res    (o_event_res),
        .o_event_ms     (o_event_ms),
        .o_idle_count   (o_idle_count),
        .o_is_cancelled (o_is_cancelled),
        .o_elapsed_ms   (o_elapsed_ms)
    );

    // predicted watchdog state, as after reset
    tsw_pkg::t_ms     wall_limit  = '0;
    tsw_pkg::t_ms     quiet_limit = '0;
    tsw_pkg::t_streak quiet_needed = 16'd1;
    logic             run_started = 1'b0;
    logic             run_done    = 1'b0;
    logic             run_cancelled = 1'b0;
    tsw_pkg::t_time   run_begin   = '0;
    tsw_pkg::t_time   progress_mark = '0;
    tsw_pkg::t_streak quiet_streak = '0;
    logic             wall_reported = 1'b0;
    logic             stall_reported = 1'b0;

    t_outcome       pending_outcomes[$];
    t_outcome       head_outcome;
    int unsigned    mismatch_count = 0;
    int unsigned    results_seen   = 0;
    int unsigned    quiet_cycles   = 0;
    int unsigned    gap_pct        = 0;
    int unsigned    stall_pct      = 0;
    logic           ready_hold     = 1'b0;
    tsw_pkg::t_time clock_ms       = '0;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic tsw_pkg::t_ms clamp_ms(input tsw_pkg::t_time v);
        if (v > tsw_pkg::t_time'(tsw_pkg::MS_MAX))
            return tsw_pkg::MS_MAX;
        return tsw_pkg::t_ms'(v);
    endfunction

    // advance the predicted state by one event and return the result it gives
    function automatic t_outcome watchdog_outcome(input tsw_pkg::t_kind kind,
                                                  input tsw_pkg::t_time now);
        t_outcome       o;
        tsw_pkg::t_time run_ms;
        tsw_pkg::t_time quiet_ms;
        o = '0;
        if (!run_done) begin
            run_ms = run_started ? now - run_begin : '0;
            case (kind)
                tsw_pkg::KIND_START: begin
                    run_started    = 1'b1;
                    run_begin      = now;
                    progress_mark  = '0;
                    quiet_streak   = '0;
                    wall_reported  = 1'b0;
                    stall_reported = 1'b0;
                end
                tsw_pkg::KIND_PROGRESS: begin
                    progress_mark  = run_ms;
                    quiet_streak   = '0;
                    stall_reported = 1'b0;
                end
                tsw_pkg::KIND_FINISH: begin
                    run_done = 1'b1;
                end
                tsw_pkg::KIND_CANCEL: begin
                    run_done      = 1'b1;
                    run_cancelled = 1'b1;
                    o.res         = tsw_pkg::RES_CANCELLED;
                end
                tsw_pkg::KIND_TICK: begin
                    if (run_started) begin
                        if (wall_limit != '0 && run_ms >= tsw_pkg::t_time'(wall_limit)
                                && !wall_reported) begin
                            wall_reported = 1'b1;
                            o.res = tsw_pkg::RES_WALL;
                            o.ms  = clamp_ms(run_ms);
                        end else if (quiet_limit != '0) begin
                            quiet_ms = run_ms - progress_mark;
                            if (quiet_ms < tsw_pkg::t_time'(quiet_limit)) begin
                                quiet_streak = '0;
                            end else begin
                                if (quiet_streak != tsw_pkg::STREAK_MAX)
                                    quiet_streak = quiet_streak + 1'b1;
                                if (quiet_streak >= quiet_needed && !stall_reported) begin
                                    stall_reported = 1'b1;
                                    o.res  = tsw_pkg::RES_STALLED;
                                    o.ms   = clamp_ms(quiet_ms);
                                    o.idle = quiet_streak;
                                end
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
        o.cancelled = run_cancelled;
        o.elapsed   = run_started ? clamp_ms(now - run_begin) : '0;
        return o;
    endfunction

    task automatic note_mismatch(input string text);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on result %0d: %0s", results_seen, text);
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
            note_mismatch($sformatf("%0s expected %0d, got %0d", field, want, got));
    endtask

    // result side: random stalls, plus a long hold-off when asked
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_ready <= 1'b0;
        else
            i_ready <= !ready_hold && ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_outcomes.size() == 0) begin
                note_mismatch("result with no request outstanding");
            end else begin
                head_outcome = pending_outcomes.pop_front();
                check_field("event_res", 32'(head_outcome.res), 32'(o_event_res));
                check_field("event_ms", 32'(head_outcome.ms), 32'(o_event_ms));
                check_field("idle_count", 32'(head_outcome.idle), 32'(o_idle_count));
                check_field("is_cancelled", 32'(head_outcome.cancelled),
                            32'(o_is_cancelled));
                check_field("elapsed_ms", 32'(head_outcome.elapsed), 32'(o_elapsed_ms));
            end
        end
    end

    // ends the run if no request of any kind is taken for too long
    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    task automatic set_idle(input int unsigned gap, input int unsigned stall);
        gap_pct   <= gap;
        stall_pct <= stall;
    endtask

    // valid stays high after the request so that back-to-back events need no drop
    task automatic send_event(input tsw_pkg::t_kind kind, input tsw_pkg::t_time now);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_kind   <= kind;
        i_now_ms <= now;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        pending_outcomes.push_back(watchdog_outcome(kind, now));
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input tsw_pkg::t_cidx idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
        case (idx)
            tsw_pkg::REG_WALL_LIMIT:  wall_limit   = data[tsw_pkg::MS_W-1:0];
            tsw_pkg::REG_STALL_THR:   quiet_limit  = data[tsw_pkg::MS_W-1:0];
            tsw_pkg::REG_IDLE_NEEDED: quiet_needed = data[tsw_pkg::STREAK_W-1:0];
            default: ;
        endcase
    endtask

    // unused upper bits carry junk, the block must drop them
    task automatic set_config(input tsw_pkg::t_ms wall, input tsw_pkg::t_ms thr,
                              input tsw_pkg::t_streak need);
        if ($urandom_range(3) == 0)
            write_reg(REG_SPARE, $urandom());
        write_reg(tsw_pkg::REG_WALL_LIMIT, {1'($urandom_range(1)), wall});
        write_reg(tsw_pkg::REG_STALL_THR, {1'($urandom_range(1)), thr});
        write_reg(tsw_pkg::REG_IDLE_NEEDED, {16'($urandom()), need});
        i_cfg_valid <= 1'b0;
    endtask

    // reset settings: ticks and progress before start, unknown kinds, wrapped start
    task automatic test_before_start();
        send_event(tsw_pkg::KIND_TICK, 32'hFFFF_FFFF);
        send_event(tsw_pkg::KIND_PROGRESS, 32'h0000_0000);
        send_event(KIND_SPARE_LO, 32'h1234_5678);
        send_event(KIND_SPARE_LO + 3'd1, 32'h8765_4321);
        send_event(KIND_SPARE_HI, 32'h5555_AAAA);
        send_event(tsw_pkg::KIND_START, 32'hFFFF_FFF0);
        send_event(tsw_pkg::KIND_TICK, 32'h0000_0005);
        send_event(tsw_pkg::KIND_PROGRESS, 32'h0000_0010);
        wait_drain();
    endtask

    // zero ticks needed, wall taking priority, stall re-armed by progress, restart
    task automatic test_stall_and_wall();
        set_config(tsw_pkg::t_ms'(100), tsw_pkg::t_ms'(10), tsw_pkg::t_streak'(0));
        clock_ms = 32'h0000_1000;
        send_event(tsw_pkg::KIND_START, clock_ms);
        send_event(tsw_pkg::KIND_TICK, clock_ms + 50);
        send_event(tsw_pkg::KIND_TICK, clock_ms + 60);
        send_event(tsw_pkg::KIND_TICK, clock_ms + 100);
        send_event(tsw_pkg::KIND_TICK, clock_ms + 200);
        send_event(tsw_pkg::KIND_PROGRESS, clock_ms + 205);
        send_event(tsw_pkg::KIND_TICK, clock_ms + 207);
        send_event(tsw_pkg::KIND_TICK, clock_ms + 220);
        send_event(tsw_pkg::KIND_START, clock_ms + 300);
        send_event(tsw_pkg::KIND_TICK, clock_ms + 450);
        wait_drain();
    endtask

    // largest limits: saturated elapsed and silence across the 2^31 boundary
    task automatic test_limit_extremes();
        set_config(tsw_pkg::MS_MAX, tsw_pkg::MS_MAX, tsw_pkg::STREAK_MAX);
        send_event(tsw_pkg::KIND_START, 32'h0000_0000);
        send_event(tsw_pkg::KIND_TICK, 32'h7FFF_FFFF);
        send_event(tsw_pkg::KIND_TICK, 32'hFFFF_FFFF);
        send_event(tsw_pkg::KIND_PROGRESS, 32'h8000_0000);
        send_event(tsw_pkg::KIND_TICK, 32'h8000_0001);
        wait_drain();
    endtask

    task automatic test_random_traffic(input int unsigned n_items, input int unsigned gap,
                                       input int unsigned stall);
        tsw_pkg::t_ms     wall;
        tsw_pkg::t_ms     thr;
        tsw_pkg::t_streak need;
        tsw_pkg::t_kind   kind;
        int unsigned      roll;
        int unsigned      span;
        int unsigned      done;
        wait_drain();
        set_idle(gap, stall);
        roll = $urandom_range(9);
        wall = (roll == 0) ? '0 : (roll == 1) ? tsw_pkg::MS_MAX
                                              : tsw_pkg::t_ms'($urandom_range(1500, 1));
        roll = $urandom_range(9);
        thr  = (roll == 0) ? '0 : (roll == 1) ? tsw_pkg::MS_MAX
                                              : tsw_pkg::t_ms'($urandom_range(300, 1));
        roll = $urandom_range(9);
        need = (roll == 0) ? '0 : (roll == 1) ? tsw_pkg::STREAK_MAX
                                              : tsw_pkg::t_streak'($urandom_range(5, 1));
        set_config(wall, thr, need);
        // steps near half the threshold so silences straddle it
        span = (thr != '0 && thr < tsw_pkg::t_ms'(1000)) ? 32'(thr / 2 + 1) : 150;
        clock_ms = $urandom();
        send_event(tsw_pkg::KIND_START, clock_ms);
        done = 0;
        while (done < n_items) begin
            roll = $urandom_range(99);
            if (roll < 4)
                kind = tsw_pkg::t_kind'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
            else if (roll < 9)
                kind = tsw_pkg::KIND_START;
            else if (roll < 30)
                kind = tsw_pkg::KIND_PROGRESS;
            else
                kind = tsw_pkg::KIND_TICK;
            roll = $urandom_range(99);
            if (roll < 2)
                clock_ms = $urandom();
            else if (roll >= 6)
                clock_ms = clock_ms + $urandom_range(span);
            send_event(kind, clock_ms);
            if (kind <= tsw_pkg::KIND_TICK)
                done++;
        end
    endtask

    // results held back until the block stops taking events, then a full drain
    task automatic test_backpressure();
        int n;
        wait_drain();
        set_idle(0, 0);
        set_config(tsw_pkg::t_ms'(400), tsw_pkg::t_ms'(20), tsw_pkg::t_streak'(2));
        fork
            begin
                ready_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                ready_hold <= 1'b0;
            end
            begin
                clock_ms = clock_ms + 7;
                send_event(tsw_pkg::KIND_START, clock_ms);
                for (n = 0; n < 40; n++) begin
                    clock_ms = clock_ms + $urandom_range(15);
                    send_event((n % 5 == 4) ? tsw_pkg::KIND_PROGRESS : tsw_pkg::KIND_TICK,
                               clock_ms);
                end
            end
        join
        wait_drain();
        for (n = 0; n < 20; n++) begin
            clock_ms = clock_ms + $urandom_range(30);
            send_event(tsw_pkg::KIND_TICK, clock_ms);
        end
        wait_drain();
    endtask

    // finish and cancel in random order; after the first everything is ignored
    task automatic test_termination();
        tsw_pkg::t_kind first_end;
        tsw_pkg::t_kind second_end;
        set_idle(13, 13);
        set_config(tsw_pkg::t_ms'(500), tsw_pkg::t_ms'(30), tsw_pkg::t_streak'(1));
        clock_ms = clock_ms + 11;
        send_event(tsw_pkg::KIND_START, clock_ms);
        clock_ms = clock_ms + 40;
        send_event(tsw_pkg::KIND_TICK, clock_ms);
        if ($urandom_range(1)) begin
            first_end  = tsw_pkg::KIND_CANCEL;
            second_end = tsw_pkg::KIND_FINISH;
        end else begin
            first_end  = tsw_pkg::KIND_FINISH;
            second_end = tsw_pkg::KIND_CANCEL;
        end
        send_event(first_end, clock_ms + 1);
        send_event(second_end, clock_ms + 2);
        send_event(tsw_pkg::KIND_START, 32'h0000_0000);
        send_event(tsw_pkg::KIND_PROGRESS, 32'hFFFF_FFFF);
        send_event(tsw_pkg::KIND_TICK, clock_ms + 1000);
        send_event(KIND_SPARE_HI, clock_ms);
        send_event(first_end, clock_ms + 600);
        wait_drain();
        set_config(tsw_pkg::t_ms'(1), tsw_pkg::MS_MAX, '0);
        send_event(tsw_pkg::KIND_TICK, clock_ms - 5);
        send_event(tsw_pkg::KIND_TICK, clock_ms + 2000);
        wait_drain();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_before_start();
        test_stall_and_wall();
        test_limit_extremes();
        for (int p = 0; p < 8; p++)
            test_random_traffic(PHASE_ITEMS, GAP_MODE[p % 4], STALL_MODE[p % 4]);
        test_backpressure();
        test_termination();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && pending_outcomes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

/* filelist.f */
rtl/tsw_pkg.sv
rtl/task_stall_watchdog.sv
sim/task_stall_watchdog_tb.sv
